// File: hw/rtl/mcg_pkg.sv
// Shared types, constants, tables and microcode for the month calendar grid block.
package mcg_pkg;

  // Widths of the stream payloads.
  localparam int YearW     = 14;
  localparam int MonthW    = 4;
  localparam int DayW      = 5;
  localparam int SDataW    = 24;
  localparam int MDataW    = 8;

  // Datapath widths.
  localparam int QuarterW  = YearW - 2;   // year / 4
  localparam int RecipW    = 18;
  localparam int ProdW     = QuarterW + RecipW;
  localparam int QuotW     = 8;           // (year / 4) / 25 stays below 164
  localparam int RecipSh   = 22;
  localparam int AccW      = 15;
  localparam int PosW      = 6;           // up to 42 cells
  localparam int ColW      = 3;

  localparam logic [YearW-1:0]  BaseYear    = 14'd1582;
  localparam logic [AccW-1:0]   BaseWeekday = 15'd5;
  // ceil(2^22 / 25): exact quotient by 25 for every 12-bit operand.
  localparam logic [RecipW-1:0] Recip25     = 18'd167773;
  localparam logic [ColW-1:0]   LastCol     = 3'd6;
  localparam logic [3:0]        Seven       = 4'd7;

  // Microprogram addresses.
  localparam logic [2:0] PC_WAIT = 3'd0;
  localparam logic [2:0] PC_MULA = 3'd1;
  localparam logic [2:0] PC_ACCA = 3'd2;
  localparam logic [2:0] PC_MULB = 3'd3;
  localparam logic [2:0] PC_LEAP = 3'd4;
  localparam logic [2:0] PC_FOLD = 3'd5;
  localparam logic [2:0] PC_LEAD = 3'd6;
  localparam logic [2:0] PC_EMIT = 3'd7;

  // Jump conditions; a taken jump loads the target, else the step counter advances.
  localparam logic [1:0] COND_NEVER   = 2'd0;
  localparam logic [1:0] COND_NO_WORD = 2'd1;
  localparam logic [1:0] COND_EMPTY   = 2'd2;
  localparam logic [1:0] COND_MORE    = 2'd3;

  // Multiplier operand selects.
  localparam logic MUL_PREV_YEAR = 1'b0;
  localparam logic MUL_THIS_YEAR = 1'b1;

  typedef struct packed {
    logic       take_in;
    logic       mul_en;
    logic       mul_sel;
    logic       acc_en;
    logic       leap_en;
    logic       fold_en;
    logic       lead_en;
    logic       emit;
    logic [1:0] cond;
    logic [2:0] target;
  } ucode_t;

  function automatic ucode_t ucode(input logic [2:0] pc);
    ucode_t w;
    w = '0;
    case (pc)
      PC_WAIT: begin
        w.take_in = 1'b1;
        w.cond    = COND_NO_WORD;
        w.target  = PC_WAIT;
      end
      PC_MULA: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_PREV_YEAR;
      end
      PC_ACCA: w.acc_en = 1'b1;
      PC_MULB: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_THIS_YEAR;
      end
      PC_LEAP: w.leap_en = 1'b1;
      PC_FOLD: w.fold_en = 1'b1;
      PC_LEAD: begin
        w.lead_en = 1'b1;
        w.cond    = COND_EMPTY;
        w.target  = PC_WAIT;
      end
      PC_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_MORE;
        w.target = PC_EMIT;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  // Reduces a 15-bit value modulo 7 by summing its octal digits (8 is 1 mod 7).
  function automatic logic [2:0] mod7(input logic [AccW-1:0] x);
    logic [5:0] s;
    logic [3:0] t;
    s = {3'd0, x[2:0]} + {3'd0, x[5:3]} + {3'd0, x[8:6]}
      + {3'd0, x[11:9]} + {3'd0, x[14:12]};
    t = {1'b0, s[5:3]} + {1'b0, s[2:0]};
    if (t >= Seven) begin
      t = t - Seven;
    end
    return t[2:0];
  endfunction

  // Days before the month in a common year, modulo 7.
  function automatic logic [2:0] month_offset(input logic [MonthW-1:0] m);
    logic [2:0] r;
    case (m)
      4'd0, 4'd1, 4'd10:        r = 3'd0;
      4'd2, 4'd3, 4'd11:        r = 3'd3;
      4'd4, 4'd7:               r = 3'd6;
      4'd5, 4'd13, 4'd14, 4'd15: r = 3'd1;
      4'd6:                     r = 3'd4;
      4'd8:                     r = 3'd2;
      4'd9, 4'd12:              r = 3'd5;
      default:                  r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/month_calendar_grid.sv
// Gregorian month calendar grid: a microcoded sequencer that emits one grid cell per word.
// Requests are taken only in the wait step; the first cell follows the setup steps.
// Each request runs the wait step, 6 setup steps and then the grid cells (28 to 42 for
// a real month, 0 or 7 otherwise), one per cycle unless m_tready stalls the output.
// The setup steps share one 12 by 18 bit multiplier that divides by 25, used twice.
// Reset: synchronous active-high rst returns the step counter to the wait step.
module month_calendar_grid (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [13:0] year, [17:14] month, [23:18] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [4:0] day_number, [7:5] zero
  output logic        m_tuser,   // [0] row_end
  output logic        m_tlast    // last cell of the grid
);

  // Step counter and the control word it selects from the microprogram.
  logic [2:0]          pc;
  logic [2:0]          pc_next;
  mcg_pkg::ucode_t     uw;

  // Datapath registers.
  logic [mcg_pkg::YearW-1:0]    yr;
  logic [mcg_pkg::MonthW-1:0]   mon;
  logic [mcg_pkg::QuarterW-1:0] quarter;   // operand last sent to the multiplier
  logic [mcg_pkg::ProdW-1:0]    prod;
  logic [mcg_pkg::AccW-1:0]     acc;
  logic                         leap;
  logic [2:0]                   lead;
  logic [mcg_pkg::PosW-1:0]     end_pos;   // lead plus month length
  logic [mcg_pkg::PosW-1:0]     pos;
  logic [mcg_pkg::ColW-1:0]     col;

  // Combinational datapath.
  logic [mcg_pkg::YearW-1:0]    prev_year;
  logic [mcg_pkg::QuarterW-1:0] mul_op;
  logic [mcg_pkg::QuotW-1:0]    quot;
  logic [mcg_pkg::QuotW+4:0]    quot_x25;
  logic                         div25;
  logic [3:0]                   lead_sum;
  logic [2:0]                   lead_val;
  logic [mcg_pkg::DayW-1:0]     len_val;
  logic [mcg_pkg::PosW-1:0]     end_val;
  logic                         in_month;
  logic [mcg_pkg::PosW-1:0]     day_val;
  logic                         row_end;
  logic                         last;
  logic                         in_acc;
  logic                         out_acc;
  logic                         jump;

  assign uw = mcg_pkg::ucode(pc);

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // The multiplier works on year/4 (this year for the leap test, the year before for
  // the count of leap days). (n/4)/25 = n/100 and that quotient over 4 is n/400.
  assign prev_year = yr - 14'd1;
  assign mul_op    = (uw.mul_sel == mcg_pkg::MUL_THIS_YEAR) ? yr[mcg_pkg::YearW-1:2]
                                                            : prev_year[mcg_pkg::YearW-1:2];
  assign quot      = prod[mcg_pkg::RecipSh +: mcg_pkg::QuotW];
  assign quot_x25  = {quot, 4'd0} + {1'b0, quot, 3'd0} + {4'd0, quot, 1'b0} - {5'd0, quot};
  assign div25     = (quot_x25 == {1'b0, quarter});

  // First weekday of the month: year start, month offset and March-on leap day, modulo 7.
  assign lead_sum = {1'b0, acc[2:0]} + {1'b0, mcg_pkg::month_offset(mon)}
                  + {3'd0, leap && (mon >= 4'd3)};
  assign lead_val = (lead_sum >= mcg_pkg::Seven) ? 3'(lead_sum - mcg_pkg::Seven)
                                                 : lead_sum[2:0];
  assign len_val  = mcg_pkg::month_len(mon, leap);
  assign end_val  = {3'd0, lead_val} + {1'b0, len_val};

  // Cell contents at the current grid position.
  assign in_month = (pos >= {3'd0, lead}) && (pos < end_pos);
  assign day_val  = pos - {3'd0, lead} + 6'd1;
  assign row_end  = (col == mcg_pkg::LastCol);
  // The grid ends at the first row end at or past the last day.
  assign last     = row_end && ({1'b0, pos} + 7'd1 >= {1'b0, end_pos});

  assign s_tready = uw.take_in;
  assign m_tvalid = uw.emit;
  assign m_tdata  = {3'd0, in_month ? day_val[mcg_pkg::DayW-1:0] : 5'd0};
  assign m_tuser  = row_end;
  assign m_tlast  = last;

  always_comb begin
    case (uw.cond)
      mcg_pkg::COND_NEVER:   jump = 1'b0;
      mcg_pkg::COND_NO_WORD: jump = !in_acc;
      mcg_pkg::COND_EMPTY:   jump = (end_val == 6'd0);
      mcg_pkg::COND_MORE:    jump = !(out_acc && last);
      default:               jump = 1'b0;
    endcase
    pc_next = jump ? uw.target : pc + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mcg_pkg::PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      yr  <= s_tdata[13:0];
      mon <= s_tdata[17:14];
    end
    if (uw.mul_en) begin
      quarter <= mul_op;
      prod    <= {{mcg_pkg::RecipW{1'b0}}, mul_op} * {{mcg_pkg::QuarterW{1'b0}}, mcg_pkg::Recip25};
    end
    if (uw.acc_en) begin
      // Each year is 1 mod 7 days plus its leap day; the base weekday and the leap
      // days before 1582 cancel modulo 7.
      if (yr < mcg_pkg::BaseYear) begin
        acc <= mcg_pkg::BaseWeekday;
      end else begin
        acc <= {1'b0, yr - mcg_pkg::BaseYear} + {3'd0, quarter}
             - {7'd0, quot} + {9'd0, quot[mcg_pkg::QuotW-1:2]};
      end
    end
    if (uw.leap_en) begin
      leap <= (yr[1:0] == 2'd0) && (!div25 || (quot[1:0] == 2'd0));
    end
    if (uw.fold_en) begin
      acc <= {12'd0, mcg_pkg::mod7(acc)};
    end
    if (uw.lead_en) begin
      lead    <= lead_val;
      end_pos <= end_val;
      pos     <= '0;
      col     <= '0;
    end
    if (out_acc) begin
      pos <= pos + 6'd1;
      col <= row_end ? 3'd0 : col + 3'd1;
    end
  end

  // The two sides are never open in the same cycle.
  a_sides_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output open together");

  // An accepted request starts the setup program.
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (pc == mcg_pkg::PC_MULA))
    else $error("setup did not start after an accepted word");

  // The grid always closes on a row end.
  a_last_row_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("last cell is not a row end");

  // The grid never runs past six rows.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pos < 6'd42) && (lead < 3'd7))
    else $error("grid position out of range");

  // After the last cell is taken the block waits for the next request.
  a_return: assert property (@(posedge clk) disable iff (rst)
    (out_acc && m_tlast) |=> (pc == mcg_pkg::PC_WAIT))
    else $error("sequencer did not return to wait");

endmodule
